>>> rtl/ppc_pkg.sv
// Shared types and constants for the point-in-polygon crossing unit.
package ppc_pkg;

	localparam int unsigned SLOT_W  = 6;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TEST  = 1'b1
	} op_t;

	// Control part of a token moving down the cell chain.
	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic              parity;
	} ctl_t;

endpackage

>>> rtl/ppc_cell.sv
// One edge cell: holds vertex INDEX and, but for the last cell, a copy of vertex INDEX+1; tests one edge per token.
module ppc_cell #(
	parameter int unsigned COORD_BITS   = 16,
	parameter int unsigned MAX_VERTICES = 64,
	parameter int unsigned INDEX        = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]   n_used,
	input  ppc_pkg::ctl_t                       in_ctl,
	input  logic signed [COORD_BITS-1:0]        in_x,
	input  logic signed [COORD_BITS-1:0]        in_y,
	input  logic signed [COORD_BITS-1:0]        in_v0x,
	input  logic signed [COORD_BITS-1:0]        in_v0y,
	output ppc_pkg::ctl_t                       out_ctl,
	output logic signed [COORD_BITS-1:0]        out_x,
	output logic signed [COORD_BITS-1:0]        out_y,
	output logic signed [COORD_BITS-1:0]        out_v0x,
	output logic signed [COORD_BITS-1:0]        out_v0y
);

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned PW = 2 * DW;

	logic signed [COORD_BITS-1:0] own_x_q, own_y_q;
	logic signed [COORD_BITS-1:0] nxt_x, nxt_y;
	logic signed [COORD_BITS-1:0] v0x_cur, v0y_cur;
	logic signed [COORD_BITS-1:0] vi_x, vi_y;
	logic                         is_last, active, is_write, is_test;
	logic                         straddle, xcond, cand;
	logic signed [DW-1:0]         d_py, d_ex, d_px, d_ey;
	logic signed [PW-1:0]         lhs, rhs;

	ppc_pkg::ctl_t                ctl_s1, ctl_s2;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, v0x_s1, v0y_s1;
	logic signed [COORD_BITS-1:0] x_s2, y_s2, v0x_s2, v0y_s2;
	logic signed [PW-1:0]         lhs_s1, rhs_s1;
	logic                         dypos_s1, cand_s1, left;

	assign is_write = in_ctl.valid && (in_ctl.op == ppc_pkg::OP_WRITE);
	assign is_test  = in_ctl.valid && (in_ctl.op == ppc_pkg::OP_TEST);

	always_ff @(posedge clk) begin
		if (is_write && (32'(in_ctl.slot) == INDEX)) begin
			own_x_q <= in_x;
			own_y_q <= in_y;
		end
	end

	generate
		if (INDEX + 1 < MAX_VERTICES) begin : g_next
			logic signed [COORD_BITS-1:0] nxt_x_q, nxt_y_q;
			// shadow of the neighbor's vertex, updated as the write passes here
			always_ff @(posedge clk) begin
				if (is_write && (32'(in_ctl.slot) == INDEX + 1)) begin
					nxt_x_q <= in_x;
					nxt_y_q <= in_y;
				end
			end
			assign nxt_x = nxt_x_q;
			assign nxt_y = nxt_y_q;
		end else begin : g_tail
			assign nxt_x = v0x_cur;
			assign nxt_y = v0y_cur;
		end
	endgenerate

	// cell 0 stamps vertex 0 onto the token for the closing edge
	assign v0x_cur = (INDEX == 0) ? own_x_q : in_v0x;
	assign v0y_cur = (INDEX == 0) ? own_y_q : in_v0y;

	assign is_last = (32'(n_used) == INDEX + 1);
	assign active  = (32'(n_used) > INDEX);
	assign vi_x    = is_last ? v0x_cur : nxt_x;
	assign vi_y    = is_last ? v0y_cur : nxt_y;

	// edge runs from own vertex (j) to the following one (i)
	always_comb begin
		straddle = ((vi_y < in_y) && (own_y_q >= in_y)) ||
		           ((own_y_q < in_y) && (vi_y >= in_y));
		xcond    = (vi_x <= in_x) || (own_x_q <= in_x);
		cand     = is_test && active && straddle && xcond;
		d_py     = DW'(in_y) - DW'(vi_y);
		d_ex     = DW'(own_x_q) - DW'(vi_x);
		d_px     = DW'(in_x) - DW'(vi_x);
		d_ey     = DW'(own_y_q) - DW'(vi_y);
		lhs      = d_py * d_ex;
		rhs      = d_px * d_ey;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= in_x;
		y_s1     <= in_y;
		v0x_s1   <= v0x_cur;
		v0y_s1   <= v0y_cur;
		lhs_s1   <= lhs;
		rhs_s1   <= rhs;
		dypos_s1 <= (own_y_q > vi_y);
		cand_s1  <= cand;
	end

	assign left = dypos_s1 ? (lhs_s1 < rhs_s1) : (rhs_s1 < lhs_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= '{valid:  ctl_s1.valid,
			            op:     ctl_s1.op,
			            slot:   ctl_s1.slot,
			            parity: ctl_s1.parity ^ (cand_s1 && left)};
		end
	end

	always_ff @(posedge clk) begin
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		v0x_s2 <= v0x_s1;
		v0y_s2 <= v0y_s1;
	end

	assign out_ctl = ctl_s2;
	assign out_x   = x_s2;
	assign out_y   = y_s2;
	assign out_v0x = v0x_s2;
	assign out_v0y = v0y_s2;

endmodule

>>> rtl/point_in_polygon_crossing_unit.sv
// Point-in-polygon unit: a new item may be started every clock (busy stays low). Vertex writes
// and point tests travel in order down a chain of MAX_VERTICES edge cells, two register stages
// per cell; a test's result appears on done/inside_res when its token leaves the last cell, so
// the chain length alone sets its delay, not vertex_count. Results are strobed for one cycle and
// cannot be held off. vertex_count is saturated to MAX_VERTICES; a count of 0 reads outside.
module point_in_polygon_crossing_unit #(
	parameter int unsigned MAX_VERTICES = 64,
	parameter int unsigned COORD_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  op,
	input  logic [ppc_pkg::SLOT_W-1:0]            vertex_index,
	input  logic signed [COORD_BITS-1:0]          coord_x,
	input  logic signed [COORD_BITS-1:0]          coord_y,
	output logic                                  done,
	output logic                                  inside_res,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [1:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

	logic [ppc_pkg::COUNT_W-1:0]  count_q;
	logic [CNT_W-1:0]             n_sat;
	ppc_pkg::ctl_t                in_ctl_s0;
	logic signed [COORD_BITS-1:0] in_x_s0, in_y_s0;

	ppc_pkg::ctl_t                chain_ctl [0:MAX_VERTICES];
	logic signed [COORD_BITS-1:0] chain_x   [0:MAX_VERTICES];
	logic signed [COORD_BITS-1:0] chain_y   [0:MAX_VERTICES];
	logic signed [COORD_BITS-1:0] chain_v0x [0:MAX_VERTICES];
	logic signed [COORD_BITS-1:0] chain_v0y [0:MAX_VERTICES];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign prdata = 32'(count_q);

	// single register; every word offset of the small window maps onto it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == paddr)) begin
			count_q <= pwdata[ppc_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		if (32'(count_q) > MAX_VERTICES) begin
			n_sat = CNT_W'(MAX_VERTICES);
		end else begin
			n_sat = CNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ctl_s0 <= '0;
		end else begin
			in_ctl_s0 <= '{valid:  start && !busy,
			               op:     ppc_pkg::op_t'(op),
			               slot:   vertex_index,
			               parity: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		in_x_s0 <= coord_x;
		in_y_s0 <= coord_y;
	end

	assign chain_ctl[0] = in_ctl_s0;
	assign chain_x[0]   = in_x_s0;
	assign chain_y[0]   = in_y_s0;
	assign chain_v0x[0] = '0;
	assign chain_v0y[0] = '0;

	generate
		for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
			ppc_cell #(
				.COORD_BITS  (COORD_BITS),
				.MAX_VERTICES(MAX_VERTICES),
				.INDEX       (k)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.n_used (n_sat),
				.in_ctl (chain_ctl[k]),
				.in_x   (chain_x[k]),
				.in_y   (chain_y[k]),
				.in_v0x (chain_v0x[k]),
				.in_v0y (chain_v0y[k]),
				.out_ctl(chain_ctl[k+1]),
				.out_x  (chain_x[k+1]),
				.out_y  (chain_y[k+1]),
				.out_v0x(chain_v0x[k+1]),
				.out_v0y(chain_v0y[k+1])
			);
		end
	endgenerate

	// last cell's stage-two register is the result register
	assign done       = chain_ctl[MAX_VERTICES].valid &&
	                    (chain_ctl[MAX_VERTICES].op == ppc_pkg::OP_TEST);
	assign inside_res = chain_ctl[MAX_VERTICES].parity;

endmodule

>>> rtl/ppc_checker.sv
// Port-level checks for the point-in-polygon unit, bound onto the top level.
module ppc_checker #(
	parameter int unsigned MAX_VERTICES = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        op,
	input logic        done,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic        pready,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	localparam int unsigned LAT   = 2 * MAX_VERTICES + 1;
	localparam int unsigned AGE_W = $clog2(LAT + 1);

	logic [AGE_W-1:0] age_q;

	// cycles since reset release, saturating at the result latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (32'(age_q) < LAT) begin
			age_q <= age_q + 1'b1;
		end
	end

	a_done_has_test: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && op, LAT))
		else $error("result strobe without a matching test transfer");

	a_test_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		((32'(age_q) == LAT) && $past(start && !busy && op, LAT)) |-> done)
		else $error("test transfer produced no result");

	a_count_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready) |=> (prdata == {25'b0, $past(pwdata[6:0])}))
		else $error("vertex_count readback mismatch");

endmodule

bind point_in_polygon_crossing_unit ppc_checker #(.MAX_VERTICES(MAX_VERTICES)) u_ppc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.op     (op),
	.done   (done),
	.psel   (psel),
	.penable(penable),
	.pwrite (pwrite),
	.pready (pready),
	.pwdata (pwdata),
	.prdata (prdata)
);

>>> tb/sv/point_in_polygon_crossing_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the point-in-polygon crossing unit: vertex loads, point tests, APB setup.
module point_in_polygon_crossing_unit_test;

	localparam int MAX_V          = 64;
	localparam int LATENCY        = 2 * MAX_V + 1;
	localparam int ITEM_TARGET    = 900;
	localparam int WATCHDOG_LIMIT = 20 * LATENCY;
	localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

	typedef enum logic {
		ROW_ITEM  = 1'b0,
		ROW_COUNT = 1'b1
	} row_kind_t;

	// directed stimulus; for ROW_COUNT the x column carries the vertex count
	typedef struct packed {
		row_kind_t                  kind;
		ppc_pkg::op_t               item_op;
		logic [ppc_pkg::SLOT_W-1:0] slot;
		int                         x;
		int                         y;
		bit                         typed;
		bit                         want;
	} stim_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         op;
	logic [ppc_pkg::SLOT_W-1:0]   vertex_index;
	logic signed [15:0]           coord_x;
	logic signed [15:0]           coord_y;
	logic                         done;
	logic                         inside_res;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [1:0]                   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	// shadow copy of the polygon held by the block
	logic signed [15:0]           poly_x [MAX_V];
	logic signed [15:0]           poly_y [MAX_V];
	logic [ppc_pkg::COUNT_W-1:0]  poly_count;

	bit                  pending_inside [$];
	bit                  want_inside;
	int                  mismatch_count;
	int                  items_sent;
	int                  burst_left;
	int                  idle_cycles;
	stim_row_t           directed_rows [18];

	point_in_polygon_crossing_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.done         (done),
		.inside_res   (inside_res),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// even-odd crossing count, exact integer compare instead of division
	function automatic bit crossing_parity(logic signed [15:0] px_in, logic signed [15:0] py_in);
		int      n;
		int      j;
		bit      odd;
		bit      left;
		longint  px, py, xi, yi, xj, yj, dy, lhs, rhs;
		px = px_in;
		py = py_in;
		n = (poly_count > MAX_V) ? MAX_V : int'(poly_count);
		odd = 1'b0;
		if (n == 0)
			return 1'b0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = poly_x[i];
			yi = poly_y[i];
			xj = poly_x[j];
			yj = poly_y[j];
			if (((yi < py && yj >= py) || (yj < py && yi >= py)) && (xi <= px || xj <= px)) begin
				dy = yj - yi;
				lhs = (py - yi) * (xj - xi);
				rhs = (px - xi) * dy;
				left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
				if (left)
					odd = ~odd;
			end
			j = i;
		end
		return odd;
	endfunction

	// span 0 means the full 16-bit range
	function automatic logic signed [15:0] rand_coord(int span);
		int v;
		if (span == 0)
			return 16'($urandom);
		v = int'($urandom_range(0, 2 * span)) - span;
		return v[15:0];
	endfunction

	// sender pacing: bursts of random length, random gaps, some back-to-back runs
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				op <= 1'($urandom);
				vertex_index <= ppc_pkg::SLOT_W'($urandom);
				coord_x <= 16'($urandom);
				coord_y <= 16'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic send_item(ppc_pkg::op_t item_op, logic [ppc_pkg::SLOT_W-1:0] slot,
			logic signed [15:0] x, logic signed [15:0] y, bit typed, bit want);
		@(negedge clk);
		start <= 1'b1;
		op <= item_op;
		vertex_index <= slot;
		coord_x <= x;
		coord_y <= y;
		do @(posedge clk); while (busy);
		// transfer accepted
		items_sent++;
		if (item_op == ppc_pkg::OP_WRITE) begin
			poly_x[slot] = x;
			poly_y[slot] = y;
		end else begin
			pending_inside.push_back(typed ? want : crossing_parity(x, y));
		end
		pace();
	endtask

	// quiet the sender, collect every result, then let vertex writes clear the chain
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_inside.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic set_vertex_count(logic [ppc_pkg::COUNT_W-1:0] cnt);
		settle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_VERTEX_COUNT;
		pwdata <= 32'(cnt);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		poly_count = cnt;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_inside.size() == 0) begin
				$display("%0t: unexpected result, expected none, got inside_res=%0b", $time,
					inside_res);
				mismatch_count++;
			end else begin
				want_inside = pending_inside.pop_front();
				if (inside_res !== want_inside) begin
					$display("%0t: inside_res mismatch, expected %0b, got %0b", $time,
						want_inside, inside_res);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("point_in_polygon_crossing_unit_test failed");
		$finish;
	end

	initial begin
		int                 cnt;
		int                 n;
		int                 span;
		int                 probes;
		int                 pick;
		int                 v;
		int                 dx;
		int                 dy;
		int                 phase;
		logic signed [15:0] px;
		logic signed [15:0] py;

		arst_n = 1'b0;
		start = 1'b0;
		op = ppc_pkg::OP_WRITE;
		vertex_index = '0;
		coord_x = '0;
		coord_y = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		poly_count = '0;
		mismatch_count = 0;
		items_sent = 0;
		burst_left = 0;
		for (int s = 0; s < MAX_V; s++) begin
			poly_x[s] = '0;
			poly_y[s] = '0;
		end

		// empty polygon, then a square spanning the whole coordinate range
		directed_rows = '{
			'{ROW_COUNT, ppc_pkg::OP_WRITE, 6'd0,       0,      0, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd0,  -32768, -32768, 1'b1, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd63,  32767,  32767, 1'b1, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd21,      0,      0, 1'b1, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_WRITE, 6'd0,  -32768, -32768, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_WRITE, 6'd1,   32767, -32768, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_WRITE, 6'd2,   32767,  32767, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_WRITE, 6'd3,  -32768,  32767, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_WRITE, 6'd63,     -1,      1, 1'b0, 1'b0},
			'{ROW_COUNT, ppc_pkg::OP_WRITE, 6'd0,       4,      0, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd42,      0,      0, 1'b1, 1'b1},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd0,  -32768, -32768, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd0,   32767,  32767, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd0,  -32768,      0, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd0,   32767,      0, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd0,       0,  32767, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd0,       0, -32768, 1'b0, 1'b0},
			'{ROW_ITEM,  ppc_pkg::OP_TEST,  6'd0,      -1,     -1, 1'b0, 1'b0}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_COUNT)
				set_vertex_count(directed_rows[r].x[ppc_pkg::COUNT_W-1:0]);
			else
				send_item(directed_rows[r].item_op, directed_rows[r].slot,
					directed_rows[r].x[15:0], directed_rows[r].y[15:0],
					directed_rows[r].typed, directed_rows[r].want);
		end

		// load every slot once so that any vertex count reads written entries only
		for (int s = 0; s < MAX_V; s++) begin
			send_item(ppc_pkg::OP_WRITE, ppc_pkg::SLOT_W'(s), rand_coord(0), rand_coord(0),
				1'b0, 1'b0);
			if ($urandom_range(0, 3) == 0)
				send_item(ppc_pkg::OP_TEST, ppc_pkg::SLOT_W'($urandom), rand_coord(0),
					rand_coord(0), 1'b0, 1'b0);
		end

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: cnt = 64;
				1: cnt = 0;
				2: cnt = 127;
				3: cnt = 1;
				4: cnt = 65;
				5: cnt = 2;
				default: begin
					cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
						: $urandom_range(3, 16);
				end
			endcase
			set_vertex_count(cnt[ppc_pkg::COUNT_W-1:0]);
			case ($urandom_range(0, 3))
				0: span = 0;
				1: span = 8;
				2: span = 300;
				default: span = 5000;
			endcase
			n = (cnt > MAX_V) ? MAX_V : cnt;

			// load a fresh polygon, then probe it
			for (int s = 0; s < n; s++)
				send_item(ppc_pkg::OP_WRITE, ppc_pkg::SLOT_W'(s), rand_coord(span),
					rand_coord(span), 1'b0, 1'b0);
			probes = $urandom_range(15, 45);
			repeat (probes) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					// rewrite a slot mid-stream
					send_item(ppc_pkg::OP_WRITE, ppc_pkg::SLOT_W'($urandom), rand_coord(span),
						rand_coord(span), 1'b0, 1'b0);
				end else begin
					if (pick <= 3 && n > 0) begin
						// on or next to a vertex: ties in x and y
						v = $urandom_range(0, n - 1);
						dx = int'($urandom_range(0, 2)) - 1;
						dy = int'($urandom_range(0, 2)) - 1;
						px = poly_x[v] + dx[15:0];
						py = poly_y[v] + dy[15:0];
					end else if (pick == 4) begin
						px = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
						py = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
					end else begin
						px = rand_coord(span);
						py = rand_coord(span);
					end
					send_item(ppc_pkg::OP_TEST, ppc_pkg::SLOT_W'($urandom), px, py,
						1'b0, 1'b0);
				end
			end
			phase++;
		end

		settle();
		if (mismatch_count == 0)
			$display("point_in_polygon_crossing_unit_test passed");
		else
			$display("point_in_polygon_crossing_unit_test failed");
		$finish;
	end

endmodule
